@@ sv/ascii_integer_parser_core_macros.svh @@
// Assertion helpers shared by the parser core.
`ifndef ASCII_INTEGER_PARSER_CORE_MACROS_SVH
`define ASCII_INTEGER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, gated off by the given disable condition.
`define AIP_ASSERT_IMPLY(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("parser core: same-cycle check failed");

// Next-cycle implication, gated off by the given disable condition.
`define AIP_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("parser core: next-cycle check failed");

`endif

@@ sv/aip_pkg.sv @@
package aip_pkg;

   localparam int unsigned AIP_COUNT_WIDTH = 16;
   localparam int unsigned AIP_QUEUE_DEPTH = 4;
   localparam int unsigned AIP_QPTR_WIDTH  = $clog2(AIP_QUEUE_DEPTH);
   localparam int unsigned AIP_QLVL_WIDTH  = $clog2(AIP_QUEUE_DEPTH + 1);

   localparam int unsigned AIP_VALUE_WIDTH    = 64;
   localparam int unsigned AIP_CONSUMED_WIDTH = 16;
   localparam int unsigned AIP_BASE_WIDTH     = 6;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;

   localparam logic [5:0] NO_DIGIT  = 6'd63;
   localparam logic [5:0] BASE_AUTO = 6'd0;
   localparam logic [5:0] BASE_OCT  = 6'd8;
   localparam logic [5:0] BASE_DEC  = 6'd10;
   localparam logic [5:0] BASE_HEX  = 6'd16;

   // Pre-decoded character as it travels from the front to the back.
   typedef struct packed {
      logic       first;
      logic       blank;
      logic       plus;
      logic       minus;
      logic       zero;
      logic       lower_x;
      logic [5:0] digit;
   } aip_class_type;

   typedef struct packed {
      logic [AIP_QLVL_WIDTH-1:0] level;
      logic                      full;
      logic                      empty;
   } aip_qstat_type;

endpackage

@@ sv/aip_ifs.sv @@
interface aip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       first_char;

   modport source (output valid, output char_code, output first_char, input ready);
   modport sink (input valid, input char_code, input first_char, output ready);
endinterface

interface aip_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;
   logic [15:0]        consumed;
   logic               finished;

   modport source (output valid, output value, output consumed, output finished,
                   input ready);
   modport sink (input valid, input value, input consumed, input finished,
                 output ready);
endinterface

interface aip_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] number_base;

   modport source (output valid, output number_base, input ready);
   modport sink (input valid, input number_base, output ready);
endinterface

@@ sv/ascii_integer_parser_core.sv @@
// A result passes through the front register, the queue and the back-end result
// register. Throughput: one character per cycle while the result side does not stall;
// the accumulate step (64-bit by 6-bit multiply-add in the back end) is combinational.
// A four-entry queue between front and back absorbs result-side stalls.
// Reset (synchronous): parse state clears to blank skipping, base register to 0.
`include "ascii_integer_parser_core_macros.svh"

module ascii_integer_parser_core
   import aip_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = AIP_COUNT_WIDTH
) (
   input logic        clock,
   input logic        reset,
   aip_req_if.sink    req_ch,
   aip_rsp_if.source  rsp_ch,
   aip_csr_if.sink    csr_ch
);

   logic [5:0]    base_ff;
   logic          push, pop;
   aip_class_type push_item, pop_item;
   aip_qstat_type q_stat;
   logic [63:0]   value_bits;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_AUTO;
      end else if (csr_ch.valid) begin
         base_ff <= csr_ch.number_base;
      end
   end

   aip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_char   (req_ch.char_code),
      .in_first  (req_ch.first_char),
      .push      (push),
      .push_item (push_item),
      .q_full    (q_stat.full)
   );

   aip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .stat      (q_stat)
   );

   aip_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .number_base  (base_ff),
      .item         (pop_item),
      .q_empty      (q_stat.empty),
      .pop          (pop),
      .out_valid    (rsp_ch.valid),
      .out_ready    (rsp_ch.ready),
      .out_value    (value_bits),
      .out_consumed (rsp_ch.consumed),
      .out_finished (rsp_ch.finished)
   );

   assign rsp_ch.value = $signed(value_bits);

   `AIP_ASSERT_IMPLY(a_push_not_full, clock, reset, push, !q_stat.full)
   `AIP_ASSERT_IMPLY(a_level_bound, clock, reset, 1'b1,
                     q_stat.level <= AIP_QLVL_WIDTH'(AIP_QUEUE_DEPTH))
   `AIP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset,
                    !rsp_ch.valid && q_stat.empty)
   `AIP_ASSERT_IMPLY(a_pop_has_word, clock, reset, pop, !q_stat.empty)

endmodule

@@ sv/aip_front.sv @@
module aip_front
   import aip_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [7:0]    in_char,
   input  logic          in_first,
   output logic          push,
   output aip_class_type push_item,
   input  logic          q_full
);

   logic          valid_ff, valid_in;
   aip_class_type item_ff, item_in;
   logic [7:0]    off;

   // Map a character to its digit value, NO_DIGIT when it is none.
   always_comb begin
      off = 8'd0;
      item_in.digit = NO_DIGIT;
      if (in_char inside {[CH_ZERO:CH_NINE]}) begin
         off = in_char - CH_ZERO;
         item_in.digit = off[5:0];
      end else if (in_char inside {[CH_LO_A:CH_LO_Z]}) begin
         off = in_char - CH_LO_A + 8'd10;
         item_in.digit = off[5:0];
      end else if (in_char inside {[CH_UP_A:CH_UP_Z]}) begin
         off = in_char - CH_UP_A + 8'd10;
         item_in.digit = off[5:0];
      end
      item_in.first   = in_first;
      item_in.blank   = (in_char == CH_SPACE) || (in_char == CH_TAB);
      item_in.plus    = (in_char == CH_PLUS);
      item_in.minus   = (in_char == CH_MINUS);
      item_in.zero    = (in_char == CH_ZERO);
      item_in.lower_x = (in_char == CH_LO_X);
   end

   assign push      = valid_ff && !q_full;
   assign in_ready  = !valid_ff || !q_full;
   assign push_item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ sv/aip_queue.sv @@
module aip_queue
   import aip_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  aip_class_type push_item,
   input  logic          pop,
   output aip_class_type pop_item,
   output aip_qstat_type stat
);

   aip_class_type             slot_ff [AIP_QUEUE_DEPTH];
   logic [AIP_QPTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [AIP_QLVL_WIDTH-1:0] level_ff, level_in;
   logic                      do_push, do_pop;

   localparam logic [AIP_QLVL_WIDTH-1:0] LVL_FULL = AIP_QLVL_WIDTH'(AIP_QUEUE_DEPTH);
   localparam logic [AIP_QPTR_WIDTH-1:0] PTR_LAST = AIP_QPTR_WIDTH'(AIP_QUEUE_DEPTH - 1);

   assign stat.level = level_ff;
   assign stat.full  = (level_ff == LVL_FULL);
   assign stat.empty = (level_ff == '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;

   always_comb begin
      level_in = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ sv/aip_back.sv @@
module aip_back
   import aip_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = AIP_COUNT_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [5:0]    number_base,
   input  aip_class_type item,
   input  logic          q_empty,
   output logic          pop,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [63:0]   out_value,
   output logic [15:0]   out_consumed,
   output logic          out_finished
);

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_SIGNED,
      PH_ZERO,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   neg_ff, neg_in;
   logic [63:0]            acc_ff, acc_in;
   logic [5:0]             base_ff, base_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic                   valid_ff, valid_in;
   logic                   took;
   logic [COUNT_WIDTH+15:0] cnt_wide;

   // Advance when a word waits and the result slot is free or being drained.
   assign pop = !q_empty && (!valid_ff || out_ready);

   always_comb begin
      phase_in = item.first ? PH_SKIP : phase_ff;
      neg_in   = item.first ? 1'b0 : neg_ff;
      acc_in   = item.first ? '0 : acc_ff;
      base_in  = item.first ? '0 : base_ff;
      cnt_in   = item.first ? '0 : cnt_ff;
      done_in  = 1'b0;
      took     = 1'b0;

      if (phase_in == PH_SKIP) begin
         if (item.blank) begin
            took = 1'b1;
         end else if (item.plus) begin
            took     = 1'b1;
            phase_in = PH_SIGNED;
         end else if (item.minus) begin
            took     = 1'b1;
            neg_in   = 1'b1;
            phase_in = PH_SIGNED;
         end else begin
            phase_in = PH_SIGNED;
         end
      end

      // Sample the base register as the sign phase ends.
      if (!took && phase_in == PH_SIGNED) begin
         if (item.zero && (number_base == BASE_AUTO || number_base == BASE_HEX)) begin
            took     = 1'b1;
            base_in  = number_base;
            phase_in = PH_ZERO;
         end else begin
            base_in  = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
            phase_in = PH_DIGITS;
         end
      end

      if (!took && phase_in == PH_ZERO) begin
         if (item.lower_x) begin
            took    = 1'b1;
            base_in = BASE_HEX;
         end else begin
            base_in = (base_in == BASE_AUTO) ? BASE_OCT : BASE_HEX;
         end
         phase_in = PH_DIGITS;
      end

      if (!took && phase_in == PH_DIGITS) begin
         if (item.digit < base_in) begin
            acc_in = acc_in * {58'd0, base_in} + {58'd0, item.digit};
            took   = 1'b1;
         end else begin
            phase_in = PH_DONE;
         end
      end

      if (!took && phase_in == PH_DONE) begin
         done_in = 1'b1;
      end

      // Hold the count once it reaches its ceiling.
      if (took && cnt_in != '1) begin
         cnt_in = cnt_in + 1'b1;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         base_ff  <= '0;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            acc_ff   <= acc_in;
            base_ff  <= base_in;
            cnt_ff   <= cnt_in;
            done_ff  <= done_in;
         end
      end
   end

   assign cnt_wide     = {16'd0, cnt_ff};
   assign out_valid    = valid_ff;
   assign out_value    = neg_ff ? (64'd0 - acc_ff) : acc_ff;
   assign out_consumed = cnt_wide[15:0];
   assign out_finished = done_ff;

endmodule

@@ test/ascii_integer_parser_core_tb.sv @@
`timescale 1ns / 1ps

module ascii_integer_parser_core_tb
   import aip_pkg::*;
();

   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 60;
   localparam int PHASE_CHARS   = 60;

   typedef enum logic [2:0] {
      SKIP_BLANKS,
      SIGN_DONE,
      ZERO_SEEN,
      IN_DIGITS,
      PARSE_ENDED
   } parse_phase_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic [15:0]        consumed;
      logic               finished;
   } parse_result_type;

   typedef struct packed {
      logic [5:0]       radix;
      logic [7:0]       code;
      logic             restart;
      logic             pinned;
      parse_result_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   aip_req_if req_ch ();
   aip_rsp_if rsp_ch ();
   aip_csr_if csr_ch ();

   ascii_integer_parser_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   parse_phase_type cur_phase;
   logic            cur_negative;
   logic [63:0]     cur_accum;
   logic [5:0]      cur_radix;
   logic [15:0]     cur_count;
   logic [5:0]      base_setting;

   parse_result_type pending_results[$];
   stim_row_type     dir_rows[$];

   parse_result_type pinned_result;
   logic             pinned_now;
   logic             steady_send;
   int               burst_left;
   int               error_count;
   int               result_index;
   int               chars_sent;
   int               hold_req;
   int               hold_served;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [5:0] char_digit(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return 6'(c - CH_ZERO);
      if (c >= CH_LO_A && c <= CH_LO_Z) return 6'(c - CH_LO_A + 8'd10);
      if (c >= CH_UP_A && c <= CH_UP_Z) return 6'(c - CH_UP_A + 8'd10);
      return NO_DIGIT;
   endfunction

   function automatic parse_result_type parse_char(input logic [7:0] c, input logic restart);
      logic             took;
      logic             ended;
      logic [5:0]       digit;
      parse_result_type res;
      took  = 1'b0;
      ended = 1'b0;
      if (restart) begin
         cur_phase    = SKIP_BLANKS;
         cur_negative = 1'b0;
         cur_accum    = '0;
         cur_radix    = '0;
         cur_count    = '0;
      end
      if (cur_phase == SKIP_BLANKS) begin
         if (c == CH_SPACE || c == CH_TAB) begin
            took = 1'b1;
         end else if (c == CH_PLUS) begin
            took      = 1'b1;
            cur_phase = SIGN_DONE;
         end else if (c == CH_MINUS) begin
            took         = 1'b1;
            cur_negative = 1'b1;
            cur_phase    = SIGN_DONE;
         end else begin
            cur_phase = SIGN_DONE;
         end
      end
      // the base register is latched here
      if (!took && cur_phase == SIGN_DONE) begin
         if (c == CH_ZERO && (base_setting == BASE_AUTO || base_setting == BASE_HEX)) begin
            took      = 1'b1;
            cur_radix = base_setting;
            cur_phase = ZERO_SEEN;
         end else begin
            cur_radix = (base_setting == BASE_AUTO) ? BASE_DEC : base_setting;
            cur_phase = IN_DIGITS;
         end
      end
      if (!took && cur_phase == ZERO_SEEN) begin
         if (c == CH_LO_X) begin
            took      = 1'b1;
            cur_radix = BASE_HEX;
         end else begin
            cur_radix = (cur_radix == BASE_AUTO) ? BASE_OCT : BASE_HEX;
         end
         cur_phase = IN_DIGITS;
      end
      if (!took && cur_phase == IN_DIGITS) begin
         digit = char_digit(c);
         if (digit < cur_radix) begin
            cur_accum = cur_accum * 64'(cur_radix) + 64'(digit);
            took      = 1'b1;
         end else begin
            cur_phase = PARSE_ENDED;
         end
      end
      if (!took && cur_phase == PARSE_ENDED) ended = 1'b1;
      if (took && cur_count != '1) cur_count = cur_count + 16'd1;
      res.value    = cur_negative ? (64'd0 - cur_accum) : cur_accum;
      res.consumed = cur_count;
      res.finished = ended;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < 100)
         $display("ERROR result %0d: %s got 0x%0h want 0x%0h", result_index, what, got, want);
      error_count++;
   endtask

   // scoreboard
   always @(posedge clock) begin
      parse_result_type want;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) base_setting = csr_ch.number_base;
         if (req_ch.valid && req_ch.ready) begin
            want = parse_char(req_ch.char_code, req_ch.first_char);
            if (pinned_now) want = pinned_result;
            pending_results.push_back(want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result, value", rsp_ch.value, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.value !== want.value)
                  report_mismatch("value", rsp_ch.value, want.value);
               if (rsp_ch.consumed !== want.consumed)
                  report_mismatch("consumed", 64'(rsp_ch.consumed), 64'(want.consumed));
               if (rsp_ch.finished !== want.finished)
                  report_mismatch("finished", 64'(rsp_ch.finished), 64'(want.finished));
            end
            result_index++;
         end
      end
   end

   // result side: random stall patterns, plus a long hold-off on request
   initial begin
      int mode;
      int left;
      int hold;
      mode         = 0;
      left         = 0;
      hold         = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_served) begin
            hold_served = hold_req;
            hold        = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(10, 60);
            end
            left--;
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   task automatic send_char(input logic [7:0] c, input logic restart, input logic pin,
                            input parse_result_type want);
      int gap;
      if (!steady_send) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_ch.valid      <= 1'b1;
      req_ch.char_code  <= c;
      req_ch.first_char <= restart;
      pinned_now        <= pin;
      pinned_result     <= want;
      do @(posedge clock); while (!req_ch.ready);
      chars_sent++;
   endtask

   // hold the input until every result is back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      // let the scoreboard log the last accepted word first
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(input logic [5:0] radix);
      csr_ch.valid       <= 1'b1;
      csr_ch.number_base <= radix;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic add_row(input logic [5:0] radix, input logic [7:0] code, input logic restart,
                          input logic pinned, input longint value, input int consumed,
                          input logic finished);
      stim_row_type row;
      row.radix         = radix;
      row.code          = code;
      row.restart       = restart;
      row.pinned        = pinned;
      row.want.value    = value;
      row.want.consumed = 16'(consumed);
      row.want.finished = finished;
      dir_rows.push_back(row);
   endtask

   function automatic logic [7:0] digit_char(input int d);
      if (d < 10) return CH_ZERO + 8'(d);
      return (($urandom_range(0, 1) != 0) ? CH_LO_A : CH_UP_A) + 8'(d - 10);
   endfunction

   // one parse: mostly well-formed numbers, some noise and broken strings
   task automatic send_number(input logic [5:0] radix);
      logic [7:0] seq[$];
      int         digits;
      int         radix_eff;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 3))
            seq.push_back(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
         case ($urandom_range(0, 2))
            1: seq.push_back(CH_PLUS);
            2: seq.push_back(CH_MINUS);
            default: ;
         endcase
         radix_eff = (radix > 6'd36) ? 36 : int'(radix);
         if (radix == BASE_AUTO) begin
            case ($urandom_range(0, 2))
               0: begin
                  seq.push_back(CH_ZERO);
                  seq.push_back(CH_LO_X);
                  radix_eff = 16;
               end
               1: begin
                  seq.push_back(CH_ZERO);
                  radix_eff = 8;
               end
               default: radix_eff = 10;
            endcase
         end else if (radix == BASE_HEX && $urandom_range(0, 1) != 0) begin
            seq.push_back(CH_ZERO);
            seq.push_back(CH_LO_X);
         end
         digits = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 26) : $urandom_range(1, 6);
         repeat (digits) begin
            if ($urandom_range(0, 19) == 0)
               seq.push_back(8'($urandom_range(0, 255)));
            else
               seq.push_back(digit_char($urandom_range(0, radix_eff - 1)));
         end
         case ($urandom_range(0, 4))
            0: seq.push_back(8'h00);
            1: seq.push_back(CH_SPACE);
            2: seq.push_back(($urandom_range(0, 1) != 0) ? CH_LO_X : "X");
            3: seq.push_back((radix_eff < 36) ? digit_char(radix_eff)
                                              : 8'($urandom_range(0, 255)));
            default: seq.push_back(8'($urandom_range(0, 255)));
         endcase
         repeat ($urandom_range(0, 2)) seq.push_back(8'($urandom_range(0, 255)));
      end
      foreach (seq[k])
         send_char(seq[k], (k == 0) || ($urandom_range(0, 49) == 0), 1'b0, '0);
   endtask

   initial begin
      logic [5:0] phase_bases[10];
      logic [5:0] current_base;
      int         target;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.char_code   = '0;
      req_ch.first_char  = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.number_base = '0;
      pinned_now         = 1'b0;
      pinned_result      = '0;
      steady_send        = 1'b0;
      burst_left         = 0;
      error_count        = 0;
      result_index       = 0;
      chars_sent         = 0;
      hold_req           = 0;
      hold_served        = 0;
      cur_phase          = SKIP_BLANKS;
      cur_negative       = 1'b0;
      cur_accum          = '0;
      cur_radix          = '0;
      cur_count          = '0;
      base_setting       = BASE_AUTO;
      current_base       = BASE_AUTO;

      // radix, char, restart, pinned, value, consumed, finished
      add_row(6'd0,  CH_SPACE, 1, 1, 0, 1, 0);
      add_row(6'd0,  CH_MINUS, 0, 1, 0, 2, 0);
      add_row(6'd0,  CH_ZERO,  0, 1, 0, 3, 0);
      add_row(6'd0,  CH_LO_X,  0, 1, 0, 4, 0);
      add_row(6'd0,  "f",      0, 1, -15, 5, 0);
      add_row(6'd0,  "G",      0, 1, -15, 5, 1);
      add_row(6'd0,  "1",      0, 1, -15, 5, 1);
      add_row(6'd0,  CH_ZERO,  1, 0, 0, 0, 0);
      add_row(6'd0,  "7",      0, 1, 7, 2, 0);
      add_row(6'd0,  "8",      0, 1, 7, 2, 1);
      add_row(6'd0,  CH_ZERO,  1, 0, 0, 0, 0);
      add_row(6'd0,  "X",      0, 1, 0, 1, 1);
      add_row(6'd0,  CH_ZERO,  1, 0, 0, 0, 0);
      add_row(6'd0,  CH_LO_X,  0, 0, 0, 0, 0);
      add_row(6'd0,  "g",      0, 1, 0, 2, 1);
      add_row(6'd0,  8'h00,    1, 1, 0, 0, 1);
      add_row(6'd16, CH_ZERO,  1, 0, 0, 0, 0);
      add_row(6'd16, CH_LO_X,  0, 0, 0, 0, 0);
      add_row(6'd16, "A",      0, 1, 10, 3, 0);
      add_row(6'd36, "z",      1, 1, 35, 1, 0);
      add_row(6'd36, "Z",      0, 0, 0, 0, 0);
      add_row(6'd1,  CH_ZERO,  1, 0, 0, 0, 0);
      add_row(6'd1,  "1",      0, 1, 0, 1, 1);
      add_row(6'd63, "z",      1, 1, 35, 1, 0);
      add_row(6'd63, "9",      0, 0, 0, 0, 0);
      add_row(6'd2,  8'hFF,    1, 1, 0, 0, 1);
      // base changes while blanks are skipped, then after the sign phase
      add_row(6'd10, CH_TAB,   1, 0, 0, 0, 0);
      add_row(6'd16, "f",      0, 1, 15, 2, 0);
      add_row(6'd2,  "a",      0, 1, 250, 3, 0);

      phase_bases = '{6'd0, 6'd10, 6'd16, 6'd2, 6'd8, 6'd36, 6'd1, 6'd63,
                      6'($urandom_range(0, 63)), 6'd0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].radix != current_base) begin
            wait_idle();
            write_base(dir_rows[i].radix);
            current_base = dir_rows[i].radix;
         end
         send_char(dir_rows[i].code, dir_rows[i].restart, dir_rows[i].pinned,
                   dir_rows[i].want);
      end

      foreach (phase_bases[p]) begin
         wait_idle();
         write_base(phase_bases[p]);
         // fill the block against a stalled result side
         steady_send = (p == 2);
         if (p == 2) hold_req++;
         target = chars_sent + PHASE_CHARS;
         while (chars_sent < target) send_number(phase_bases[p]);
      end
      steady_send = 1'b0;

      wait_idle();
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
